@@ hdl/mcr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, codes and types of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  localparam int COORD_BITS    = 13;
  localparam int RADIUS_BITS   = 11;
  localparam int PIX_BITS      = COORD_BITS + 1;
  localparam int ERR_BITS      = RADIUS_BITS + 3;
  localparam int DIM_BITS      = 13;
  localparam int PITCH_BITS    = 15;
  localparam int ADDR_BITS     = 32;
  localparam int COLOR_BITS    = 32;
  localparam int PROD_BITS     = COORD_BITS + PITCH_BITS;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int SLOT_BITS     = 3;

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'((1 << SLOT_BITS) - 1);

  // input tdata layout
  localparam int IN_CY_LSB    = COORD_BITS;
  localparam int IN_R_LSB     = 2 * COORD_BITS;
  localparam int IN_COLOR_LSB = 2 * COORD_BITS + RADIUS_BITS;
  localparam int IN_USED      = IN_COLOR_LSB + COLOR_BITS;
  localparam int IN_TDATA_W   = ((IN_USED + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_USED     = 2 * PIX_BITS + ADDR_BITS + COLOR_BITS;
  localparam int OUT_TDATA_W  = ((OUT_USED + 7) / 8) * 8;
  localparam int OUT_TUSER_W  = 2;

  // reset values of the registers
  localparam logic [DIM_BITS-1:0]   WIDTH_RST  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RST = DIM_BITS'(480);
  localparam logic [PITCH_BITS-1:0] PITCH_RST  = PITCH_BITS'(2560);
  localparam logic [ADDR_BITS-1:0]  BASE_RST   = '0;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_STEP  = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_ROW_PITCH     = 2'd2,
    REG_FRAME_BASE    = 2'd3
  } cfg_reg_t;

  typedef logic signed [PIX_BITS-1:0]   pix_t;
  typedef logic signed [ERR_BITS:0]     ewide_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one pixel issued by the step sequencer
  typedef struct packed {
    pix_t                  x;
    pix_t                  y;
    logic [COLOR_BITS-1:0] value;
    logic                  last;
    logic                  done;
  } pix_beat_t;

  // one finished pixel
  typedef struct packed {
    pix_t                  x;
    pix_t                  y;
    logic [ADDR_BITS-1:0]  addr;
    logic [COLOR_BITS-1:0] value;
    logic                  on_screen;
    logic                  last;
    logic                  done;
  } pix_out_t;

endpackage
`default_nettype wire

@@ hdl/mcr_pix_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_pix_pipe
// Clip test and framebuffer address, three stages; one pixel per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module mcr_pix_pipe
  import mcr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  beat_valid,
  input  wire pix_beat_t             beat,
  output logic                       adv,
  input  wire logic [DIM_BITS-1:0]   width,
  input  wire logic [DIM_BITS-1:0]   height,
  input  wire logic [PITCH_BITS-1:0] pitch,
  input  wire logic [ADDR_BITS-1:0]  base,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output pix_out_t                   out_pix
);

  logic                 s1_valid_r;
  pix_beat_t            s1_beat_r;
  logic                 s1_vis_r;
  logic                 s2_valid_r;
  pix_beat_t            s2_beat_r;
  logic                 s2_vis_r;
  logic [PROD_BITS-1:0] s2_prod_r;
  logic [ADDR_BITS-1:0] s2_part_r;
  logic                 o_valid_r;
  pix_out_t             o_pix_r;
  logic                 vis;

  // whole pipe moves together; hold while the output waits
  assign adv = !o_valid_r || out_ready;

  assign vis = !beat.x[PIX_BITS-1] && !beat.y[PIX_BITS-1] &&
               (beat.x[COORD_BITS-1:0] < width) && (beat.y[COORD_BITS-1:0] < height);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= beat_valid;
      s2_valid_r <= s1_valid_r;
      o_valid_r  <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_beat_r <= beat;
      s1_vis_r  <= vis;
      s2_beat_r <= s1_beat_r;
      s2_vis_r  <= s1_vis_r;
      s2_prod_r <= PROD_BITS'(s1_beat_r.y[COORD_BITS-1:0]) * PROD_BITS'(pitch);
      s2_part_r <= base + ADDR_BITS'({s1_beat_r.x[COORD_BITS-1:0], 2'b00});
      o_pix_r.x         <= s2_beat_r.x;
      o_pix_r.y         <= s2_beat_r.y;
      o_pix_r.addr      <= s2_vis_r ? (s2_part_r + ADDR_BITS'(s2_prod_r)) : '0;
      o_pix_r.value     <= s2_beat_r.value;
      o_pix_r.on_screen <= s2_vis_r;
      o_pix_r.last      <= s2_beat_r.last;
      o_pix_r.done      <= s2_beat_r.done;
    end
  end

  assign out_valid = o_valid_r;
  assign out_pix   = o_pix_r;

endmodule
`default_nettype wire

@@ hdl/midpoint_circle_rasterizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle stepper with clip test and framebuffer address generation.
// ----------------------------------------------------------------------------
// A start item (tuser 0) latches center, radius and color.
// Each step item (tuser 1) of an active circle yields eight pixel transfers,
// one per cycle while the output does not stall. The decision variable is
// updated in the cycle the step is accepted, and the next step is accepted in
// the cycle the eighth pixel of the previous one issues, so steps follow
// without a gap. A pixel passes the clip, multiply and address-add stages
// before it leaves. Steps while no circle is active are accepted and dropped.
// Off-screen pixels are still sent with on_screen low and address zero.
// Configuration writes are taken in any cycle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer
  import mcr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // tdata: center_x[12:0], center_y[25:13], radius[36:26], color[68:37]
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [IN_TDATA_W-1:0]    in_tdata,
  // tuser: func
  input  wire logic                     in_tuser,
  // tdata: pixel_x[13:0], pixel_y[27:14], pixel_address[59:28], pixel_value[91:60]
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]        out_tdata,
  // tuser: on_screen[0], done_res[1]
  output logic [OUT_TUSER_W-1:0]        out_tuser,
  output logic                          out_tlast,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  // configuration registers
  logic [DIM_BITS-1:0]    width_r;
  logic [DIM_BITS-1:0]    height_r;
  logic [PITCH_BITS-1:0]  pitch_r;
  logic [ADDR_BITS-1:0]   base_r;

  // circle state
  logic [RADIUS_BITS-1:0] step_x_r;
  logic [RADIUS_BITS-1:0] step_y_r;
  err_t                   err_r;
  coord_t                 cx_r;
  coord_t                 cy_r;
  logic [COLOR_BITS-1:0]  color_r;
  logic                   active_r;

  // snapshot of the step being issued
  logic                   job_valid_r;
  logic [SLOT_BITS-1:0]   slot_r;
  logic [RADIUS_BITS-1:0] job_x_r;
  logic [RADIUS_BITS-1:0] job_y_r;
  coord_t                 job_cx_r;
  coord_t                 job_cy_r;
  logic [COLOR_BITS-1:0]  job_color_r;
  logic                   job_fin_r;

  // input decode
  func_t                  in_func;
  coord_t                 in_cx;
  coord_t                 in_cy;
  logic [RADIUS_BITS-1:0] in_radius;
  logic [COLOR_BITS-1:0]  in_color;
  logic                   in_xfer;

  // step update
  ewide_t                 err_inc;
  ewide_t                 err_dec;
  logic                   x_dec;
  logic [RADIUS_BITS-1:0] step_x_nxt;
  logic [RADIUS_BITS-1:0] step_y_nxt;
  err_t                   err_nxt;
  logic                   active_nxt;

  // pixel issue
  logic                   adv;
  logic                   issue;
  pix_t                   ox_xm1;
  pix_t                   ox_xn;
  pix_t                   ox_y;
  pix_t                   ox_yn;
  pix_t                   dx;
  pix_t                   dy;
  pix_beat_t              beat;
  pix_out_t               out_pix;

  assign in_func   = func_t'(in_tuser);
  assign in_cx     = in_tdata[COORD_BITS-1:0];
  assign in_cy     = in_tdata[IN_CY_LSB +: COORD_BITS];
  assign in_radius = in_tdata[IN_R_LSB +: RADIUS_BITS];
  assign in_color  = in_tdata[IN_COLOR_LSB +: COLOR_BITS];

  // take a new item when the snapshot is free or its eighth pixel leaves now
  assign in_tready = !job_valid_r || (adv && (slot_r == LAST_SLOT));
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      pitch_r  <= PITCH_RST;
      base_r   <= BASE_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  width_r  <= cfg_data[DIM_BITS-1:0];
        REG_SCREEN_HEIGHT: height_r <= cfg_data[DIM_BITS-1:0];
        REG_ROW_PITCH:     pitch_r  <= cfg_data[PITCH_BITS-1:0];
        REG_FRAME_BASE:    base_r   <= cfg_data[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---- midpoint update: err += 2Y+2, Y++, on err >= 0 X-- and err -= 2X-1 ----
  always_comb begin
    err_inc    = ewide_t'(err_r) + ewide_t'({step_y_r, 1'b0}) + ewide_t'(2);
    x_dec      = !err_inc[ERR_BITS];
    step_y_nxt = step_y_r + 1'b1;
    step_x_nxt = x_dec ? (step_x_r - 1'b1) : step_x_r;
    err_dec    = err_inc - (ewide_t'({step_x_nxt, 1'b0}) - ewide_t'(1));
    err_nxt    = x_dec ? err_dec[ERR_BITS-1:0] : err_inc[ERR_BITS-1:0];
    active_nxt = step_x_nxt > step_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= '0;
      step_y_r <= '0;
      err_r    <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
      color_r  <= '0;
      active_r <= 1'b0;
    end else if (in_xfer) begin
      if (in_func == FUNC_START) begin
        // replace any circle in progress
        cx_r     <= in_cx;
        cy_r     <= in_cy;
        color_r  <= in_color;
        step_x_r <= in_radius;
        step_y_r <= '0;
        err_r    <= err_t'(-ewide_t'(in_radius));
        active_r <= (in_radius != '0);
      end else if (active_r) begin
        step_x_r <= step_x_nxt;
        step_y_r <= step_y_nxt;
        err_r    <= err_nxt;
        active_r <= active_nxt;
      end
    end
  end

  // ---- step snapshot and pixel slot counter ----
  assign issue = job_valid_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      if (issue) begin
        slot_r <= slot_r + 1'b1;
        if (slot_r == LAST_SLOT) begin
          job_valid_r <= 1'b0;
        end
      end
      if (in_xfer && (in_func == FUNC_STEP) && active_r) begin
        job_valid_r <= 1'b1;
        slot_r      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (in_func == FUNC_STEP) && active_r) begin
      job_x_r     <= step_x_r;
      job_y_r     <= step_y_r;
      job_cx_r    <= cx_r;
      job_cy_r    <= cy_r;
      job_color_r <= color_r;
      job_fin_r   <= !active_nxt;
    end
  end

  // ---- octant offsets in output order ----
  always_comb begin
    ox_y   = pix_t'(job_y_r);
    ox_xm1 = pix_t'(job_x_r) - pix_t'(1);
    ox_xn  = -pix_t'(job_x_r);
    ox_yn  = -ox_y - pix_t'(1);
    case (slot_r)
      3'd0:    begin dx = ox_xm1; dy = ox_y;   end
      3'd1:    begin dx = ox_y;   dy = ox_xm1; end
      3'd2:    begin dx = ox_xn;  dy = ox_y;   end
      3'd3:    begin dx = ox_y;   dy = ox_xn;  end
      3'd4:    begin dx = ox_xm1; dy = ox_yn;  end
      3'd5:    begin dx = ox_yn;  dy = ox_xm1; end
      3'd6:    begin dx = ox_xn;  dy = ox_yn;  end
      default: begin dx = ox_yn;  dy = ox_xn;  end
    endcase
    beat.x     = pix_t'(job_cx_r) + dx;
    beat.y     = pix_t'(job_cy_r) + dy;
    beat.value = job_color_r;
    beat.last  = (slot_r == LAST_SLOT);
    beat.done  = (slot_r == LAST_SLOT) && job_fin_r;
  end

  mcr_pix_pipe u_pix_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (job_valid_r),
    .beat       (beat),
    .adv        (adv),
    .width      (width_r),
    .height     (height_r),
    .pitch      (pitch_r),
    .base       (base_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_pix    (out_pix)
  );

  assign out_tdata = OUT_TDATA_W'({out_pix.value, out_pix.addr, out_pix.y, out_pix.x});
  assign out_tuser = {out_pix.done, out_pix.on_screen};
  assign out_tlast = out_pix.last;

endmodule
`default_nettype wire

@@ hdl/mcr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks of the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
module mcr_checker
  import mcr_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [OUT_TDATA_W-1:0]   out_tdata,
  input wire logic [OUT_TUSER_W-1:0]   out_tuser,
  input wire logic                     out_tlast,
  input wire logic                     cfg_valid,
  input wire logic                     cfg_ready
);

  localparam int ADDR_LSB = 2 * PIX_BITS;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // the end of a circle only comes on the eighth pixel of a step
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("done without last");

  // off-screen pixels carry address zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[ADDR_LSB +: ADDR_BITS] == '0)
    else $error("off-screen pixel with nonzero address");

  // no result straight out of reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // configuration is never refused
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
// A short table of hand-picked start and step transfers runs first. It covers
// idle steps, zero radius, the smallest and largest radius, centers at both
// ends of the coordinate range, a circle cut short by a new start, and
// pixels on both sides of the screen edge. Random circles follow, under
// several screen settings, with gaps on the input and stalls on the output.
// A local copy of the stepper predicts every pixel, and each pixel that
// comes out is compared with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb;
  import mcr_pkg::*;

  // Give the pipe ample margin to run dry after the last pixel.
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_GOAL      = 36;
  localparam int PHASES        = 6;

  typedef logic [RADIUS_BITS-1:0] rad_t;

  // One row of the directed table. n_due and done_due of -1 mean "don't care".
  typedef struct packed {
    func_t                 f;
    coord_t                cx;
    coord_t                cy;
    rad_t                  r;
    logic [COLOR_BITS-1:0] color;
    byte                   n_due;
    byte                   done_due;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata;
  logic                     in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_TDATA_W-1:0]   out_tdata;
  logic [OUT_TUSER_W-1:0]   out_tuser;
  logic                     out_tlast;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  // Mirror of the screen registers, as the block should hold them.
  int               scr_w     = int'(WIDTH_RST);
  int               scr_h     = int'(HEIGHT_RST);
  int               pitch_b   = int'(PITCH_RST);
  logic [31:0]      base_addr = BASE_RST;

  // Circle state of the predictor.
  int               arc_x;
  int               arc_y;
  int               arc_err;
  int               ctr_x;
  int               ctr_y;
  logic [31:0]      ink;
  bit               drawing;

  pix_out_t         pixels_due[$];
  stim_row_t        plan_q[$];
  int               errors;
  int               tx_gap_pct;
  int               rx_stall_pct;

  midpoint_circle_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Receiver: stall at random, at the rate of the current pacing mode.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Pacing modes: slow sender and slower receiver, then the reverse, then
  // both sides at full rate.
  function automatic void set_pace(input int mode);
    case (mode)
      0: begin
        tx_gap_pct   = 31;
        rx_stall_pct = 83;
      end
      1: begin
        tx_gap_pct   = 83;
        rx_stall_pct = 31;
      end
      default: begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
    endcase
  endfunction

  // Build one expected pixel; the clip test and address use the exact
  // coordinate, only the x and y fields are cut to the port width.
  function automatic pix_out_t make_pixel(input int px, input int py, input bit tail,
                                          input bit fin);
    pix_out_t p;
    bit       vis;
    vis         = px >= 0 && py >= 0 && px < scr_w && py < scr_h;
    p.x         = pix_t'(px);
    p.y         = pix_t'(py);
    p.addr      = vis ? base_addr + 32'(py) * 32'(pitch_b) + 32'(px) * 32'd4 : '0;
    p.value     = ink;
    p.on_screen = vis;
    p.last      = tail;
    p.done      = fin;
    return p;
  endfunction

  // Advance the predicted circle by one accepted transfer and queue the
  // pixels it must produce.
  task automatic trace_item(input func_t f, input int cx, cy, r, input logic [31:0] c,
                            output int n, output bit fin);
    int x;
    int y;
    n   = 0;
    fin = 1'b0;
    if (f == FUNC_START) begin
      ctr_x   = int'(coord_t'(cx));
      ctr_y   = int'(coord_t'(cy));
      ink     = c;
      arc_x   = int'(rad_t'(r));
      arc_y   = 0;
      arc_err = -arc_x;
      drawing = arc_x > arc_y;
    end else if (drawing) begin
      x = arc_x;
      y = arc_y;
      arc_err += 2 * y + 2;
      arc_y = y + 1;
      if (arc_err >= 0) begin
        arc_x = x - 1;
        arc_err -= 2 * arc_x - 1;
      end
      drawing = arc_x > arc_y;
      fin     = !drawing;
      // Eight octants, in the order the block sends them.
      pixels_due.push_back(make_pixel(ctr_x + x - 1, ctr_y + y,     1'b0, 1'b0));
      pixels_due.push_back(make_pixel(ctr_x + y,     ctr_y + x - 1, 1'b0, 1'b0));
      pixels_due.push_back(make_pixel(ctr_x - x,     ctr_y + y,     1'b0, 1'b0));
      pixels_due.push_back(make_pixel(ctr_x + y,     ctr_y - x,     1'b0, 1'b0));
      pixels_due.push_back(make_pixel(ctr_x + x - 1, ctr_y - y - 1, 1'b0, 1'b0));
      pixels_due.push_back(make_pixel(ctr_x - y - 1, ctr_y + x - 1, 1'b0, 1'b0));
      pixels_due.push_back(make_pixel(ctr_x - x,     ctr_y - y - 1, 1'b0, 1'b0));
      pixels_due.push_back(make_pixel(ctr_x - y - 1, ctr_y - x,     1'b1, fin));
      n = 8;
    end
  endtask

  // Send one transfer, after idle cycles at the sender's rate, and predict it
  // once accepted. Step transfers carry random payload, which the block must
  // ignore.
  task automatic feed(input func_t f, input int cx, cy, r, input logic [31:0] c,
                      output int n, output bit fin);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    if (f == FUNC_START) begin
      in_tdata <= IN_TDATA_W'({c, rad_t'(r), coord_t'(cy), coord_t'(cx)});
    end else begin
      in_tdata <= IN_TDATA_W'({$urandom, $urandom, $urandom});
    end
    do @(posedge clk); while (!in_tready);
    trace_item(f, cx, cy, r, c, n, fin);
  endtask

  // Hold valid high across back-to-back writes; the caller drops it.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH:  scr_w     = int'(v[DIM_BITS-1:0]);
      REG_SCREEN_HEIGHT: scr_h     = int'(v[DIM_BITS-1:0]);
      REG_ROW_PITCH:     pitch_b   = int'(v[PITCH_BITS-1:0]);
      REG_FRAME_BASE:    base_addr = v;
      default: ;
    endcase
  endtask

  task automatic load_screen(input int w, h, p, input logic [31:0] b);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ROW_PITCH, p);
    write_reg(REG_FRAME_BASE, b);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every predicted pixel, then let the pipe run dry.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void add_row(input func_t f, input int cx, cy, r,
                                  input logic [31:0] c, input int n, d);
    stim_row_t s;
    s.f        = f;
    s.cx       = coord_t'(cx);
    s.cy       = coord_t'(cy);
    s.r        = rad_t'(r);
    s.color    = c;
    s.n_due    = byte'(n);
    s.done_due = byte'(d);
    plan_q.push_back(s);
  endfunction

  // Random circles: mostly complete runs of small radius, some large ones
  // cut short, some runs broken off early, and stray steps after each run.
  task automatic random_run(input int goal);
    int taken;
    int cx;
    int cy;
    int r;
    int cap;
    int k;
    int n;
    int span_w;
    int span_h;
    bit fin;
    taken  = 0;
    span_w = (scr_w < 4000) ? scr_w : 4000;
    span_h = (scr_h < 4000) ? scr_h : 4000;
    while (taken < goal) begin
      if ($urandom_range(4) == 0) begin
        cx = int'(coord_t'($urandom));
        cy = int'(coord_t'($urandom));
      end else begin
        // Keep centers around the visible area so clipping cuts both ways.
        cx = int'($urandom_range(0, span_w + 60)) - 30;
        cy = int'($urandom_range(0, span_h + 60)) - 30;
      end
      case ($urandom_range(9))
        0:       r = 0;
        1:       r = $urandom_range(60, 2047);
        default: r = $urandom_range(1, 16);
      endcase
      feed(FUNC_START, cx, cy, r, $urandom, n, fin);
      taken++;
      if ($urandom_range(99) < 15) begin
        cap = $urandom_range(0, 3);
      end else begin
        cap = (r > 60) ? $urandom_range(4, 24) : 64;
      end
      k = 0;
      while (drawing && k < cap) begin
        feed(FUNC_STEP, 0, 0, 0, '0, n, fin);
        k++;
        taken++;
      end
      repeat ($urandom_range(0, 2)) begin
        feed(FUNC_STEP, 0, 0, 0, '0, n, fin);
        taken++;
      end
    end
  endtask

  function automatic void check_field(input string what, input logic [31:0] want, got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    end
  endfunction

  // Compare each pixel transfer with the oldest prediction.
  always @(posedge clk) begin : watch_pixels
    pix_out_t want;
    pix_out_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x         = out_tdata[PIX_BITS-1:0];
      got.y         = out_tdata[PIX_BITS +: PIX_BITS];
      got.addr      = out_tdata[2*PIX_BITS +: ADDR_BITS];
      got.value     = out_tdata[2*PIX_BITS+ADDR_BITS +: COLOR_BITS];
      got.on_screen = out_tuser[0];
      got.done      = out_tuser[1];
      got.last      = out_tlast;
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: pixel expected none actual x=%0d y=%0d", $time, got.x, got.y);
      end else begin
        want = pixels_due.pop_front();
        check_field("pixel_x", want.x, got.x);
        check_field("pixel_y", want.y, got.y);
        check_field("pixel_address", want.addr, got.addr);
        check_field("pixel_value", want.value, got.value);
        check_field("on_screen", want.on_screen, got.on_screen);
        check_field("last", want.last, got.last);
        check_field("done_res", want.done, got.done);
      end
    end
  end

  initial begin : run
    stim_row_t row;
    int        n;
    bit        fin;
    errors     = 0;
    in_tvalid  <= 1'b0;
    in_tuser   <= FUNC_START;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_SCREEN_WIDTH;
    cfg_data   <= '0;
    rst_n      <= 1'b0;
    set_pace(0);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, run on the reset screen (640 x 480, pitch 2560, base 0).
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 0, -1); // idle after reset
    add_row(FUNC_START,   100,   100,    0, 32'h1234_5678, 0, -1); // zero radius
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 0, -1);
    add_row(FUNC_START,     0,     0,    1, 32'hFFFF_FFFF, 0, -1); // one-step circle
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  1);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 0, -1); // finished
    add_row(FUNC_START, -4096, -4096, 2047, 32'h0000_0000, 0, -1); // low corner
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  0);
    add_row(FUNC_START,  4095,  4095, 2047, 32'hA5A5_5A5A, 0, -1); // high corner
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  0);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  0);
    add_row(FUNC_START,   320,   240,    5, 32'h0000_FF00, 0, -1); // full circle
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  0);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  0);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  1);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 0, -1);
    add_row(FUNC_START,    10,    10,    3, 32'h0F0F_F0F0, 0, -1);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8, -1);
    add_row(FUNC_START,   638,   478,    4, 32'h3333_CCCC, 0, -1); // replaces, on edge
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  0);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  0);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8,  1);
    add_row(FUNC_START,   639,   479, 2047, 32'h8000_0001, 0, -1);
    add_row(FUNC_STEP,      0,     0,    0, 32'h0000_0000, 8, -1);
    add_row(FUNC_START,     0,     0,    0, 32'h0000_0000, 0, -1); // abort to idle

    foreach (plan_q[i]) begin
      row = plan_q[i];
      feed(row.f, row.cx, row.cy, row.r, row.color, n, fin);
      if (row.n_due >= 0 && n != row.n_due) begin
        errors++;
        $display("%0t: row %0d pixel count expected %0d actual %0d",
                 $time, i, row.n_due, n);
      end
      if (row.done_due >= 0 && n > 0 && fin != row.done_due[0]) begin
        errors++;
        $display("%0t: row %0d done expected %0d actual %0d",
                 $time, i, row.done_due[0], fin);
      end
    end
    settle();

    // Random part: new screen settings in each phase, written while idle.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       load_screen(1, 1, 4, 32'h0000_0000);
        1:       load_screen(4096, 4096, 16384, 32'hFFFF_FFF0); // address wraps
        2:       load_screen(0, 4096, 32767, 32'h0010_0000);    // zero width
        3:       load_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
                             $urandom_range(4, 16384), $urandom);
        4:       load_screen(8191, 8191, 32767, $urandom);
        default: load_screen(640, 0, 2560, $urandom);           // zero height
      endcase
      set_pace((p + 1) % 3);
      random_run(RUN_GOAL);
      settle();
    end

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
